// ===== hdl/nlc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// nlc_pkg
// Shared types and constants of the NAL packet layout classifier.
// ----------------------------------------------------------------------------
package nlc_pkg;

  // Number of length-prefix parsers (prefix widths 1 .. MAX_PREFIX_WIDTH)
  localparam int unsigned MAX_PREFIX_WIDTH = 4;
  // Bytes kept from the head of a packet for start code detection
  localparam int unsigned HEAD_LEN = 4;
  // Width of a count of valid parsers
  localparam int unsigned VALID_CNT_W = $clog2(MAX_PREFIX_WIDTH + 1);

  // Layout codes
  localparam logic [1:0] LAYOUT_START_CODE      = 2'd0;
  localparam logic [1:0] LAYOUT_LENGTH_PREFIXED = 2'd1;
  localparam logic [1:0] LAYOUT_AMBIGUOUS       = 2'd2;
  localparam logic [1:0] LAYOUT_NEITHER         = 2'd3;

  // One byte of a packet
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } nlc_in_t;

  // Classification of one packet
  typedef struct packed {
    logic [1:0] layout;
    logic [2:0] prefix_width;
  } nlc_out_t;

  // Per-parser status after the current byte
  typedef struct packed {
    logic fail;
    logic busy;
    logic unit_seen;
  } nlc_parse_status_t;

endpackage : nlc_pkg
`default_nettype wire

// ===== hdl/nlc_parser.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// nlc_parser
// Length-prefix parser for one prefix width: reads big-endian lengths,
// counts payload bytes and reports the parser status after each byte.
// ----------------------------------------------------------------------------
module nlc_parser (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic [2:0]                 width_i,
  input  wire logic                       step_i,
  input  wire logic                       clear_i,
  input  wire logic [7:0]                 byte_i,
  output nlc_pkg::nlc_parse_status_t      status_o
);
  import nlc_pkg::*;

  logic        in_payload_q, in_payload_d;
  logic [1:0]  prefix_cnt_q, prefix_cnt_d;
  logic [31:0] length_acc_q, length_acc_d;
  logic [31:0] remaining_q, remaining_d;
  logic        unit_seen_q, unit_seen_d;
  logic        failed_q, failed_d;

  logic [31:0] acc_next;
  logic [2:0]  cnt_inc;

  assign acc_next = {length_acc_q[23:0], byte_i};
  assign cnt_inc  = {1'b0, prefix_cnt_q} + 3'd1;

  // Advance the parser by one byte
  always_comb begin
    in_payload_d = in_payload_q;
    prefix_cnt_d = prefix_cnt_q;
    length_acc_d = length_acc_q;
    remaining_d  = remaining_q;
    unit_seen_d  = unit_seen_q;
    failed_d     = failed_q;
    if (failed_q) begin
      // hold: parser is out for this packet
    end else if (in_payload_q) begin
      remaining_d = remaining_q - 32'd1;
      if (remaining_q == 32'd1) begin
        in_payload_d = 1'b0;
        unit_seen_d  = 1'b1;
      end
    end else begin
      if (cnt_inc >= width_i) begin
        prefix_cnt_d = 2'd0;
        length_acc_d = 32'd0;
        if (acc_next == 32'd0) begin
          failed_d = 1'b1;
        end else begin
          remaining_d  = acc_next;
          in_payload_d = 1'b1;
        end
      end else begin
        prefix_cnt_d = cnt_inc[1:0];
        length_acc_d = acc_next;
      end
    end
  end

  // Report the status as it stands after this byte
  always_comb begin
    status_o.fail      = failed_d;
    status_o.busy      = in_payload_d || (prefix_cnt_d != 2'd0);
    status_o.unit_seen = unit_seen_d;
  end

  // Hold the parser state; clear it after the final byte of a packet
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_payload_q <= 1'b0;
      prefix_cnt_q <= 2'd0;
      length_acc_q <= 32'd0;
      remaining_q  <= 32'd0;
      unit_seen_q  <= 1'b0;
      failed_q     <= 1'b0;
    end else if (step_i && clear_i) begin
      in_payload_q <= 1'b0;
      prefix_cnt_q <= 2'd0;
      length_acc_q <= 32'd0;
      remaining_q  <= 32'd0;
      unit_seen_q  <= 1'b0;
      failed_q     <= 1'b0;
    end else if (step_i) begin
      in_payload_q <= in_payload_d;
      prefix_cnt_q <= prefix_cnt_d;
      length_acc_q <= length_acc_d;
      remaining_q  <= remaining_d;
      unit_seen_q  <= unit_seen_d;
      failed_q     <= failed_d;
    end
  end

endmodule : nlc_parser
`default_nettype wire

// ===== hdl/nlc_classify.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// nlc_classify
// Captures the packet head for start code detection and combines the
// parser status into the layout decision of a packet.
// ----------------------------------------------------------------------------
module nlc_classify (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  step_i,
  input  wire logic                  clear_i,
  input  wire logic [7:0]            byte_i,
  input  wire nlc_pkg::nlc_parse_status_t
                                     status_i [nlc_pkg::MAX_PREFIX_WIDTH],
  output nlc_pkg::nlc_out_t          result_o
);
  import nlc_pkg::*;

  logic [7:0] head_q [HEAD_LEN];
  logic [7:0] head_d [HEAD_LEN];
  logic [2:0] seen_q, seen_d;

  logic                   start_code;
  logic [VALID_CNT_W-1:0] valid_cnt;
  logic [2:0]             selected;
  logic                   width_ok;

  // Capture the first bytes of the packet, saturating the count
  always_comb begin
    for (int i = 0; i < HEAD_LEN; i++) begin
      head_d[i] = head_q[i];
      if (seen_q == 3'(i)) begin
        head_d[i] = byte_i;
      end
    end
    seen_d = (seen_q < 3'(HEAD_LEN)) ? seen_q + 3'd1 : seen_q;
  end

  // Detect a three- or four-byte start code at the head
  always_comb begin
    start_code = 1'b0;
    if (seen_d >= 3'd3 && head_d[0] == 8'h00 && head_d[1] == 8'h00) begin
      if (head_d[2] == 8'h01) begin
        start_code = 1'b1;
      end else if (seen_d >= 3'd4 && head_d[2] == 8'h00 && head_d[3] == 8'h01) begin
        start_code = 1'b1;
      end
    end
  end

  // Count the widths that split the packet exactly; pick the narrowest
  always_comb begin
    valid_cnt = '0;
    selected  = 3'd0;
    for (int w = MAX_PREFIX_WIDTH - 1; w >= 0; w--) begin
      width_ok = !status_i[w].fail && !status_i[w].busy && status_i[w].unit_seen;
      if (width_ok) begin
        valid_cnt = valid_cnt + VALID_CNT_W'(1);
        selected  = 3'(w + 1);
      end
    end
  end

  // Form the result
  always_comb begin
    result_o.prefix_width = 3'd0;
    if (start_code) begin
      result_o.layout = LAYOUT_START_CODE;
    end else if (valid_cnt == '0) begin
      result_o.layout = LAYOUT_NEITHER;
    end else if (valid_cnt > VALID_CNT_W'(1)) begin
      result_o.layout = LAYOUT_AMBIGUOUS;
    end else begin
      result_o.layout       = LAYOUT_LENGTH_PREFIXED;
      result_o.prefix_width = selected;
    end
  end

  // Hold the head bytes; clear after the final byte of a packet
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= 3'd0;
      for (int i = 0; i < HEAD_LEN; i++) begin
        head_q[i] <= 8'h00;
      end
    end else if (step_i && clear_i) begin
      seen_q <= 3'd0;
      for (int i = 0; i < HEAD_LEN; i++) begin
        head_q[i] <= 8'h00;
      end
    end else if (step_i) begin
      seen_q <= seen_d;
      for (int i = 0; i < HEAD_LEN; i++) begin
        head_q[i] <= head_d[i];
      end
    end
  end

endmodule : nlc_classify
`default_nettype wire

// ===== hdl/nal_packet_layout_classifier.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// nal_packet_layout_classifier
// Classifies the framing of an encoded video packet from its byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel carries one packet byte per transaction, with
//   last_byte set on the final byte. Packets are at least one byte long.
//   The output channel carries one transaction per packet: the layout
//   (start code, length prefixed, ambiguous, neither) and, for length
//   prefixed packets, the prefix width 1..4.
//   A byte is captured in an input register, then all four width parsers
//   and the head detector update from that register. The result of a
//   packet is loaded into the output register when its final byte leaves
//   the input register. One byte is taken every cycle unless the input
//   stalls; there is no gap between packets.
//   A new byte is accepted while a finished result waits on the output.
//   Only when the byte in the input register is a final byte and the
//   output register still holds an untaken result does the input stall.
//   Reset clears all parser state and the valid flags of the input and
//   output registers; parser state also clears after every final byte.
// ----------------------------------------------------------------------------
module nal_packet_layout_classifier (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output      logic              in_stall_o,
  input  wire nlc_pkg::nlc_in_t  in_data_i,
  output      logic              out_valid_o,
  input  wire logic              out_stall_i,
  output      nlc_pkg::nlc_out_t out_data_o
);
  import nlc_pkg::*;

  logic     s1_valid_q;
  nlc_in_t  s1_data_q;
  logic     out_valid_q;
  nlc_out_t out_data_q;

  logic     s1_hold;
  logic     step;
  nlc_out_t result;

  nlc_parse_status_t status [MAX_PREFIX_WIDTH];

  // Stall only a final byte that cannot yet place its result
  assign s1_hold    = s1_valid_q && s1_data_q.last_byte && out_valid_q && out_stall_i;
  assign in_stall_o = s1_hold;
  assign step       = s1_valid_q && !s1_hold;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!s1_hold) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!s1_hold && in_valid_i) begin
      s1_data_q <= in_data_i;
    end
  end

  // One parser per prefix width
  for (genvar w = 0; w < MAX_PREFIX_WIDTH; w++) begin : g_parser
    nlc_parser u_parser (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .width_i  (3'(w + 1)),
      .step_i   (step),
      .clear_i  (s1_data_q.last_byte),
      .byte_i   (s1_data_q.data_byte),
      .status_o (status[w])
    );
  end

  nlc_classify u_classify (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .clear_i  (s1_data_q.last_byte),
    .byte_i   (s1_data_q.data_byte),
    .status_i (status),
    .result_o (result)
  );

  // Output register: load on a final byte, drop once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step && s1_data_q.last_byte) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && s1_data_q.last_byte) begin
      out_data_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule : nal_packet_layout_classifier
`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the NAL packet layout classifier.
// Packets go in as byte transactions with the final byte marked. A bench-side
// copy of the four width parsers and the start code check predicts the
// classification of every packet. Each output transaction is compared field
// by field with the oldest prediction. A short directed table comes first.
// Random packets follow: mostly well-formed length-prefixed units, plus start
// codes, broken units, noise and long packets that parse at two widths. Both
// channels idle and stall in random bursts, except near the end of the run.
// ----------------------------------------------------------------------------
module tb_top;
  import nlc_pkg::*;

  localparam int unsigned ITEM_TARGET = 1050;
  localparam int unsigned CALM_AFTER  = 900;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned DIR_ROWS    = 26;

  // One row of the directed table; an expectation is typed in where fin and typed are set
  typedef struct packed {
    logic [7:0] data;
    logic       fin;
    logic       typed;
    logic [1:0] lay;
    logic [2:0] pw;
  } stim_row_t;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_stall_o;
  nlc_in_t  in_data_i   = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  nlc_out_t out_data_o;

  // Expected classifications, oldest first
  nlc_out_t    verdict_q[$];
  nlc_out_t    want;
  logic [7:0]  pkt_q[$];
  int unsigned fail_cnt  = 0;
  int unsigned sent_cnt  = 0;
  int unsigned cycle_cnt = 0;
  bit          calm      = 1'b0;
  bit          idle_on   = 1'b1;

  // Predictor state: packet head and one parser per prefix width
  logic [7:0]  head_q   [HEAD_LEN]         = '{default: '0};
  int unsigned seen_cnt                    = 0;
  bit          busy     [MAX_PREFIX_WIDTH] = '{default: 1'b0};
  int unsigned pfx_cnt  [MAX_PREFIX_WIDTH] = '{default: 0};
  logic [31:0] len_acc  [MAX_PREFIX_WIDTH] = '{default: '0};
  logic [31:0] owed     [MAX_PREFIX_WIDTH] = '{default: '0};
  bit          got_unit [MAX_PREFIX_WIDTH] = '{default: 1'b0};
  bit          dead     [MAX_PREFIX_WIDTH] = '{default: 1'b0};

  stim_row_t dir_rows [DIR_ROWS] = '{
    // one byte: zero length at width 1, partial prefix elsewhere
    '{8'h00, 1'b1, 1'b1, LAYOUT_NEITHER, 3'd0},
    // one byte: the unit overruns the packet
    '{8'h05, 1'b1, 1'b1, LAYOUT_NEITHER, 3'd0},
    // three-byte start code
    '{8'h00, 1'b0, 1'b0, LAYOUT_START_CODE, 3'd0},
    '{8'h00, 1'b0, 1'b0, LAYOUT_START_CODE, 3'd0},
    '{8'h01, 1'b1, 1'b1, LAYOUT_START_CODE, 3'd0},
    // four-byte start code
    '{8'h00, 1'b0, 1'b0, LAYOUT_START_CODE, 3'd0},
    '{8'h00, 1'b0, 1'b0, LAYOUT_START_CODE, 3'd0},
    '{8'h00, 1'b0, 1'b0, LAYOUT_START_CODE, 3'd0},
    '{8'h01, 1'b1, 1'b1, LAYOUT_START_CODE, 3'd0},
    // three zeros: no start code, zero lengths at widths 1 to 3
    '{8'h00, 1'b0, 1'b0, LAYOUT_START_CODE, 3'd0},
    '{8'h00, 1'b0, 1'b0, LAYOUT_START_CODE, 3'd0},
    '{8'h00, 1'b1, 1'b1, LAYOUT_NEITHER, 3'd0},
    // width 1 unit of two bytes, first data byte all ones
    '{8'h02, 1'b0, 1'b0, LAYOUT_START_CODE, 3'd0},
    '{8'hFF, 1'b0, 1'b0, LAYOUT_START_CODE, 3'd0},
    '{8'h80, 1'b1, 1'b0, LAYOUT_START_CODE, 3'd0},
    // width 2 unit of one byte
    '{8'h00, 1'b0, 1'b0, LAYOUT_START_CODE, 3'd0},
    '{8'h01, 1'b0, 1'b0, LAYOUT_START_CODE, 3'd0},
    '{8'h7F, 1'b1, 1'b0, LAYOUT_START_CODE, 3'd0},
    // width 2 unit followed by a prefix cut off by the end of the packet
    '{8'h00, 1'b0, 1'b0, LAYOUT_START_CODE, 3'd0},
    '{8'h01, 1'b0, 1'b0, LAYOUT_START_CODE, 3'd0},
    '{8'hAA, 1'b0, 1'b0, LAYOUT_START_CODE, 3'd0},
    '{8'h00, 1'b1, 1'b1, LAYOUT_NEITHER, 3'd0},
    // start code wins over a clean width 3 parse
    '{8'h00, 1'b0, 1'b0, LAYOUT_START_CODE, 3'd0},
    '{8'h00, 1'b0, 1'b0, LAYOUT_START_CODE, 3'd0},
    '{8'h01, 1'b0, 1'b0, LAYOUT_START_CODE, 3'd0},
    '{8'h05, 1'b1, 1'b1, LAYOUT_START_CODE, 3'd0}
  };

  nal_packet_layout_classifier DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Advance all width parsers by one byte; return 1 with the verdict on a final byte
  function automatic bit classify_byte(input nlc_in_t item, output nlc_out_t verdict);
    int unsigned hits;
    int          w;
    logic [2:0]  pick;
    bit          start_code;
    hits    = 0;
    pick    = '0;
    verdict = '0;
    if (seen_cnt < HEAD_LEN) begin
      head_q[seen_cnt] = item.data_byte;
      seen_cnt++;
    end
    for (w = 0; w < MAX_PREFIX_WIDTH; w++) begin
      if (dead[w]) continue;
      // count down the payload of the current unit
      if (busy[w]) begin
        owed[w] = owed[w] - 1;
        if (owed[w] == 0) begin
          busy[w]     = 1'b0;
          got_unit[w] = 1'b1;
        end
        continue;
      end
      // shift in one big-endian prefix byte
      len_acc[w] = {len_acc[w][23:0], item.data_byte};
      pfx_cnt[w]++;
      if (pfx_cnt[w] >= w + 1) begin
        pfx_cnt[w] = 0;
        if (len_acc[w] == 0) begin
          dead[w] = 1'b1;
        end else begin
          owed[w] = len_acc[w];
          busy[w] = 1'b1;
        end
        len_acc[w] = '0;
      end
    end
    if (!item.last_byte) return 1'b0;

    start_code = seen_cnt >= 3 && head_q[0] == 8'h00 && head_q[1] == 8'h00 &&
                 (head_q[2] == 8'h01 ||
                  (seen_cnt >= 4 && head_q[2] == 8'h00 && head_q[3] == 8'h01));
    for (w = 0; w < MAX_PREFIX_WIDTH; w++) begin
      if (!dead[w] && !busy[w] && pfx_cnt[w] == 0 && got_unit[w]) begin
        hits++;
        if (pick == 0) pick = 3'(w + 1);
      end
    end
    if (start_code) begin
      verdict.layout = LAYOUT_START_CODE;
    end else if (hits == 0) begin
      verdict.layout = LAYOUT_NEITHER;
    end else if (hits > 1) begin
      verdict.layout = LAYOUT_AMBIGUOUS;
    end else begin
      verdict.layout       = LAYOUT_LENGTH_PREFIXED;
      verdict.prefix_width = pick;
    end

    // drop all packet state
    seen_cnt = 0;
    head_q   = '{default: '0};
    busy     = '{default: 1'b0};
    pfx_cnt  = '{default: 0};
    len_acc  = '{default: '0};
    owed     = '{default: '0};
    got_unit = '{default: 1'b0};
    dead     = '{default: 1'b0};
    return 1'b1;
  endfunction

  // Drive one byte transaction, hold it through stalls, then predict
  task automatic send_byte(input nlc_in_t item, input bit typed, input nlc_out_t typed_res);
    int unsigned gap;
    nlc_out_t    res;
    gap = 0;
    if (!calm && idle_on && $urandom_range(4) == 0) gap = $urandom_range(1, 14);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (in_stall_o);
    sent_cnt++;
    if (classify_byte(item, res)) verdict_q.push_back(typed ? typed_res : res);
  endtask

  // Send the bytes of pkt_q as one packet
  task automatic send_packet();
    nlc_in_t item;
    for (int i = 0; i < pkt_q.size(); i++) begin
      item.data_byte = pkt_q[i];
      item.last_byte = (i == pkt_q.size() - 1);
      send_byte(item, 1'b0, '0);
    end
  endtask

  // Fill pkt_q with units of the given prefix width
  task automatic build_units(input int unsigned wid);
    int unsigned units;
    int unsigned len;
    units = $urandom_range(1, 3);
    repeat (units) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
      for (int i = wid - 1; i >= 0; i--) pkt_q.push_back(8'(len >> (8 * i)));
      repeat (len) pkt_q.push_back(8'($urandom_range(255)));
    end
  endtask

  // Packet that parses at widths 1 and 2: width 2 reads 256, width 1 reads units
  task automatic build_two_width();
    int unsigned left;
    int unsigned len;
    pkt_q.push_back(8'h01);
    pkt_q.push_back(8'h00);
    left = 256;
    while (left > 0) begin
      if (left <= 9) begin
        len = left - 1;
      end else begin
        len = $urandom_range(1, 8);
        if (left - 1 - len == 1) len--;
      end
      pkt_q.push_back(8'(len));
      repeat (len) pkt_q.push_back(8'($urandom_range(255)));
      left -= len + 1;
    end
  endtask

  // Fill pkt_q with one random packet of a random kind
  task automatic build_packet();
    int unsigned kind;
    int unsigned wid;
    int unsigned n;
    kind = $urandom_range(199);
    pkt_q.delete();
    if (kind < 120) begin
      wid = $urandom_range(1, MAX_PREFIX_WIDTH);
      build_units(wid);
      // break some of the well-formed packets
      if ($urandom_range(4) == 0) begin
        case ($urandom_range(2))
          0: begin
            if (pkt_q.size() > 1) void'(pkt_q.pop_back());
          end
          1: begin
            pkt_q.push_back(8'($urandom_range(255)));
          end
          default: begin
            for (int i = 0; i < wid; i++) pkt_q[i] = 8'h00;
          end
        endcase
      end
    end else if (kind < 150) begin
      if ($urandom_range(1)) begin
        pkt_q = '{8'h00, 8'h00, 8'h01};
      end else begin
        pkt_q = '{8'h00, 8'h00, 8'h00, 8'h01};
      end
      repeat ($urandom_range(6)) pkt_q.push_back(8'($urandom_range(255)));
      if ($urandom_range(3) == 0) begin
        n = $urandom_range(3);
        pkt_q[n] = 8'($urandom_range(3));
      end
    end else if (kind < 199) begin
      repeat ($urandom_range(1, 10)) begin
        pkt_q.push_back($urandom_range(1) ? 8'($urandom_range(3)) : 8'($urandom_range(255)));
      end
    end else begin
      build_two_width();
    end
  endtask

  // Random output stalls in bursts
  initial begin
    forever begin
      @(negedge clk_i);
      if (!calm && $urandom_range(7) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 14)) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
    end
  end

  // Compare each output transaction with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (verdict_q.size() == 0) begin
        $display("%0t: unexpected transaction: layout %0d width %0d", $time,
                 out_data_o.layout, out_data_o.prefix_width);
        fail_cnt++;
      end else begin
        want = verdict_q.pop_front();
        if (out_data_o.layout !== want.layout) begin
          $display("%0t: layout expected %0d actual %0d", $time, want.layout,
                   out_data_o.layout);
          fail_cnt++;
        end
        if (out_data_o.prefix_width !== want.prefix_width) begin
          $display("%0t: prefix_width expected %0d actual %0d", $time,
                   want.prefix_width, out_data_o.prefix_width);
          fail_cnt++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("nal_packet_layout_classifier: mismatch");
      $finish;
    end
  end

  initial begin
    nlc_in_t  item;
    nlc_out_t typed_res;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // walk the directed table
    for (int i = 0; i < DIR_ROWS; i++) begin
      item.data_byte         = dir_rows[i].data;
      item.last_byte         = dir_rows[i].fin;
      typed_res.layout       = dir_rows[i].lay;
      typed_res.prefix_width = dir_rows[i].pw;
      send_byte(item, dir_rows[i].fin && dir_rows[i].typed, typed_res);
    end

    // hold the sender until every classification is back
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);

    // random packets; start with one that parses at two widths
    pkt_q.delete();
    build_two_width();
    send_packet();
    while (sent_cnt < ITEM_TARGET) begin
      calm    = (sent_cnt >= CALM_AFTER);
      idle_on = ($urandom_range(3) != 0);
      build_packet();
      send_packet();
      if (!calm && $urandom_range(39) == 0) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        while (verdict_q.size() != 0) @(posedge clk_i);
      end
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("nal_packet_layout_classifier: match");
    end else begin
      $display("nal_packet_layout_classifier: mismatch");
    end
    $finish;
  end

endmodule
